// ----- rtl/pses_pkg.sv -----
// Shared types, codes and byte tables for the print spooler.
// Used by the controller, the datapath, the top level and the testbench.
package pses_pkg;

    localparam int IDX_W = 9;

    localparam logic [1:0] MODE_STRING  = 2'd0;
    localparam logic [1:0] MODE_FLUSH   = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_TICK    = 2'd3;

    localparam logic [2:0] STY_PLAIN      = 3'd0;
    localparam logic [2:0] STY_EXPANDED   = 3'd1;
    localparam logic [2:0] STY_RESET      = 3'd2;
    localparam logic [2:0] STY_COMPRESSED = 3'd3;
    localparam logic [2:0] STY_EJECT      = 3'd4;
    localparam logic [2:0] STY_RULER      = 3'd5;
    localparam logic [2:0] STY_BLANK      = 3'd6;
    localparam logic [2:0] STY_UNIT       = 3'd7;

    localparam logic [1:0] APP_NONE  = 2'd0;
    localparam logic [1:0] APP_OK    = 2'd1;
    localparam logic [1:0] APP_BUSY  = 2'd2;
    localparam logic [1:0] APP_TRUNC = 2'd3;

    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CTRL = 1'b1;

    localparam logic CFG_RULER = 1'b0;
    localparam logic CFG_EJECT = 1'b1;

    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_DASH = 8'h2d;

    localparam logic [7:0] RULER_RESET = 8'd48;
    localparam logic [4:0] EJECT_RESET = 5'd8;

    localparam logic [1:0] COLD_LAST = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {SRC_PRE, SRC_CHR, SRC_SUF} t_src;
    typedef enum logic [1:0] {EM_STATUS, EM_DONE, EM_COLD, EM_DATA} t_emit;

    typedef struct packed {
        logic       lat;
        logic       wr;
        t_src       src;
        logic       idx_clr;
        logic       ptr_clr;
        logic       rd;
        logic       load;
        t_emit      em;
        logic [1:0] status;
        logic [1:0] cold_idx;
        logic       last;
        logic [2:0] style;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic seg_end;
        logic has_data;
        logic out_free;
    } t_stat;

    function automatic logic is_fixed(input logic [2:0] s);
        return (s == STY_RESET) || (s == STY_EJECT) || (s == STY_RULER) ||
               (s == STY_BLANK) || (s == STY_UNIT);
    endfunction

    function automatic logic [7:0] unit_byte(input logic [4:0] k);
        logic [7:0] b;
        case (k)
            5'd0:    b = 8'h63;
            5'd1:    b = 8'h6d;
            5'd2:    b = CH_ESC;
            5'd3:    b = 8'h53;
            5'd4:    b = 8'h02;
            5'd5:    b = 8'h32;
            5'd6:    b = CH_ESC;
            5'd7:    b = 8'h54;
            5'd8:    b = 8'h2e;
            5'd9:    b = 8'h67;
            5'd10:   b = CH_ESC;
            5'd11:   b = 8'h53;
            5'd12:   b = 8'h02;
            5'd13:   b = 8'h2d;
            5'd14:   b = 8'h31;
            5'd15:   b = CH_ESC;
            5'd16:   b = 8'h54;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte idx of the sequence written at the start of a styled string.
    function automatic logic [7:0] pre_byte(input logic [2:0] s, input t_idx idx,
                                            input logic [7:0] ruler,
                                            input logic [4:0] feeds);
        logic [7:0] b;
        case (s)
            STY_EXPANDED:   b = (idx == t_idx'(0)) ? CH_ESC :
                                (idx == t_idx'(1)) ? 8'h57 : 8'h01;
            STY_RESET:      b = (idx == t_idx'(0)) ? CH_ESC : 8'h58;
            STY_COMPRESSED: b = 8'h0f;
            STY_EJECT:      b = (idx < t_idx'(feeds)) ? CH_LF : CH_CR;
            STY_RULER:      b = (idx < t_idx'(ruler)) ? CH_DASH :
                                (idx == t_idx'(ruler)) ? CH_CR : CH_LF;
            STY_BLANK:      b = (idx == t_idx'(0)) ? CH_CR : CH_LF;
            STY_UNIT:       b = unit_byte(idx[4:0]);
            default:        b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic pre_last(input logic [2:0] s, input t_idx idx,
                                      input logic [7:0] ruler,
                                      input logic [4:0] feeds);
        logic l;
        case (s)
            STY_EXPANDED:   l = (idx == t_idx'(2));
            STY_RESET:      l = (idx == t_idx'(1));
            STY_COMPRESSED: l = (idx == t_idx'(0));
            STY_EJECT:      l = (idx == t_idx'(feeds));
            STY_RULER:      l = (idx == t_idx'(ruler) + t_idx'(1));
            STY_BLANK:      l = (idx == t_idx'(1));
            STY_UNIT:       l = (idx == t_idx'(16));
            default:        l = 1'b1;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] suf_byte(input logic [2:0] s, input t_idx idx);
        logic [7:0] b;
        if (s == STY_EXPANDED) begin
            b = (idx == t_idx'(0)) ? CH_ESC : (idx == t_idx'(1)) ? 8'h57 : 8'h02;
        end else begin
            b = 8'h12;
        end
        return b;
    endfunction

    function automatic logic suf_last(input logic [2:0] s, input t_idx idx);
        return (s == STY_EXPANDED) ? (idx == t_idx'(2)) : 1'b1;
    endfunction

    function automatic logic [7:0] cold_byte(input logic [1:0] k);
        return (k == 2'd2) ? 8'h8f : 8'hff;
    endfunction

endpackage

// ----- rtl/pses_if.sv -----
// Valid/ready channel interfaces for the print spooler: request and result.
// Plain logic payloads; no package dependency.
interface pses_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] style;
    logic [7:0] char_byte;
    logic       has_char;
    logic       first_of_string;
    logic       last_of_string;

    modport source (output valid, mode, style, char_byte, has_char,
                    first_of_string, last_of_string, input ready);
    modport sink   (input valid, mode, style, char_byte, has_char,
                    first_of_string, last_of_string, output ready);
endinterface

interface pses_res_if;
    logic       valid;
    logic       ready;
    logic       port_select;
    logic [7:0] port_value;
    logic       strobe_res;
    logic       job_done;
    logic [1:0] append_status;
    logic       last_result;

    modport source (output valid, port_select, port_value, strobe_res, job_done,
                    append_status, last_result, input ready);
    modport sink   (input valid, port_select, port_value, strobe_res, job_done,
                    append_status, last_result, output ready);
endinterface

// ----- rtl/pses_dpath.sv -----
// Datapath of the print spooler: job buffer memory, pointers, config registers,
// escape byte generation and the result register. Depends on pses_pkg, pses_res_if.
module pses_dpath import pses_pkg::*; #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic [7:0]        i_char,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    pses_res_if.source        o_res
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int PW = $clog2(BUFFER_BYTES + 1);

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_ruler;
    logic [4:0]    r_feeds;
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    t_idx          r_idx;
    logic [7:0]    r_char;
    logic [7:0]    r_rdata;
    logic          r_ovalid;
    logic          r_sel;
    logic [7:0]    r_val;
    logic          r_strobe;
    logic          r_done;
    logic [1:0]    r_status;
    logic          r_last;
    logic [7:0]    n_byte;

    always_comb begin
        case (i_cmd.src)
            SRC_PRE: n_byte = pre_byte(i_cmd.style, r_idx, r_ruler, r_feeds);
            SRC_CHR: n_byte = r_char;
            SRC_SUF: n_byte = suf_byte(i_cmd.style, r_idx);
            default: n_byte = 8'h00;
        endcase
    end

    assign o_stat.full     = (r_wptr >= PW'(BUFFER_BYTES));
    assign o_stat.seg_end  = (i_cmd.src == SRC_PRE) ?
                             pre_last(i_cmd.style, r_idx, r_ruler, r_feeds) :
                             suf_last(i_cmd.style, r_idx);
    assign o_stat.has_data = (r_wptr > r_rptr);
    assign o_stat.out_free = !r_ovalid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wptr[AW-1:0]] <= n_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_rptr[AW-1:0]];
        end
        if (i_cmd.lat) begin
            r_char <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ruler  <= RULER_RESET;
            r_feeds  <= EJECT_RESET;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RULER: r_ruler <= i_cfg_data;
                    CFG_EJECT: r_feeds <= i_cfg_data[4:0];
                    default:   r_ruler <= r_ruler;
                endcase
            end
            if (i_cmd.ptr_clr) begin
                r_wptr <= '0;
                r_rptr <= '0;
            end else begin
                if (i_cmd.wr) begin
                    r_wptr <= r_wptr + PW'(1);
                end
                if (i_cmd.load && i_cmd.em == EM_DATA) begin
                    r_rptr <= r_rptr + PW'(1);
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.wr) begin
                r_idx <= r_idx + t_idx'(1);
            end
            if (i_cmd.load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when the register is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sel    <= PORT_DATA;
            r_val    <= 8'h00;
            r_strobe <= 1'b0;
            r_done   <= 1'b0;
            r_status <= APP_NONE;
            r_last   <= i_cmd.last;
            case (i_cmd.em)
                EM_STATUS: r_status <= i_cmd.status;
                EM_DONE:   r_done   <= 1'b1;
                EM_COLD: begin
                    r_sel <= (i_cmd.cold_idx == 2'd0) ? PORT_DATA : PORT_CTRL;
                    r_val <= cold_byte(i_cmd.cold_idx);
                end
                EM_DATA: begin
                    r_val    <= r_rdata;
                    r_strobe <= 1'b1;
                end
                default: r_status <= APP_NONE;
            endcase
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.port_select   = r_sel;
    assign o_res.port_value    = r_val;
    assign o_res.strobe_res    = r_strobe;
    assign o_res.job_done      = r_done;
    assign o_res.append_status = r_status;
    assign o_res.last_result   = r_last;

endmodule

// ----- rtl/pses_ctrl.sv -----
// Controller of the print spooler: request sequencing, printer state, job flags.
// Drives the datapath through t_cmd and reads t_stat. Depends on pses_pkg, pses_req_if.
module pses_ctrl import pses_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pses_req_if.sink    i_req,
    input  t_stat       i_stat,
    output t_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_PRE, S_CHR, S_SUF, S_RES, S_COLD, S_RD, S_DATA
    } t_state;

    typedef enum logic [2:0] {
        P_STANDBY   = 3'd0,
        P_COLD      = 3'd1,
        P_READY     = 3'd2,
        P_RUN       = 3'd3,
        P_UNHANDLED = 3'd4
    } t_prn;

    t_state     r_state;
    t_prn       r_prn;
    logic       r_pending;
    logic       r_dropped;
    logic [2:0] r_style;
    logic       r_last;
    logic       r_has;
    logic [1:0] r_status;
    t_emit      r_em;
    logic [1:0] r_cold;

    logic       acc;
    logic       need_char;
    logic       need_suf;
    logic [2:0] n_style;
    logic       n_dropped;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign need_char   = !is_fixed(r_style) && r_has;
    assign need_suf    = !is_fixed(r_style) && r_last &&
                         (r_style == STY_EXPANDED || r_style == STY_COMPRESSED);
    assign n_style     = i_req.first_of_string ? i_req.style : r_style;
    assign n_dropped   = i_req.first_of_string ? 1'b0 : r_dropped;

    always_comb begin
        o_cmd          = '0;
        o_cmd.src      = SRC_PRE;
        o_cmd.em       = r_em;
        o_cmd.status   = r_status;
        o_cmd.cold_idx = r_cold;
        o_cmd.style    = r_style;
        case (r_state)
            S_IDLE: begin
                o_cmd.idx_clr = 1'b1;
                if (acc && i_req.mode == MODE_STRING) begin
                    o_cmd.lat = 1'b1;
                end
                if (acc && i_req.mode == MODE_TICK) begin
                    o_cmd.ptr_clr = (r_prn == P_COLD) ||
                                    (r_prn == P_RUN && !i_stat.has_data);
                end
            end
            S_PRE: begin
                o_cmd.src = SRC_PRE;
                o_cmd.wr  = !i_stat.full;
            end
            S_CHR: begin
                o_cmd.src     = SRC_CHR;
                o_cmd.wr      = need_char && !i_stat.full;
                o_cmd.idx_clr = 1'b1;
            end
            S_SUF: begin
                o_cmd.src = SRC_SUF;
                o_cmd.wr  = need_suf && !i_stat.full;
            end
            S_RES: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.last = 1'b1;
            end
            S_COLD: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.em   = EM_COLD;
                o_cmd.last = (r_cold == COLD_LAST);
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_DATA: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.em   = EM_DATA;
                o_cmd.last = 1'b1;
            end
            default: o_cmd.src = SRC_PRE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prn     <= P_STANDBY;
            r_pending <= 1'b0;
            r_dropped <= 1'b0;
            r_style   <= STY_PLAIN;
            r_last    <= 1'b0;
            r_has     <= 1'b0;
            r_status  <= APP_NONE;
            r_em      <= EM_STATUS;
            r_cold    <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        case (i_req.mode)
                            MODE_STRING: begin
                                r_style <= n_style;
                                r_last  <= i_req.last_of_string;
                                r_has   <= i_req.has_char;
                                r_em    <= EM_STATUS;
                                if (n_dropped || r_pending) begin
                                    r_dropped <= !i_req.last_of_string;
                                    r_status  <= APP_BUSY;
                                    r_state   <= S_RES;
                                end else begin
                                    r_dropped <= 1'b0;
                                    r_status  <= APP_OK;
                                    r_state   <= (i_req.first_of_string &&
                                                  n_style != STY_PLAIN) ? S_PRE : S_CHR;
                                end
                            end
                            MODE_FLUSH:   r_pending <= 1'b1;
                            MODE_RESTART: r_prn     <= P_COLD;
                            MODE_TICK: begin
                                case (r_prn)
                                    P_STANDBY, P_UNHANDLED: r_prn <= r_prn;
                                    P_COLD: begin
                                        r_pending <= 1'b0;
                                        r_prn     <= P_READY;
                                        r_cold    <= 2'd0;
                                        r_state   <= S_COLD;
                                    end
                                    P_READY: begin
                                        if (r_pending) begin
                                            r_prn <= P_RUN;
                                        end
                                    end
                                    P_RUN: begin
                                        if (i_stat.has_data) begin
                                            r_state <= S_RD;
                                        end else begin
                                            r_pending <= 1'b0;
                                            r_prn     <= P_READY;
                                            r_em      <= EM_DONE;
                                            r_status  <= APP_NONE;
                                            r_state   <= S_RES;
                                        end
                                    end
                                    default: r_prn <= P_UNHANDLED;
                                endcase
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PRE: begin
                    if (i_stat.full) begin
                        r_pending <= 1'b1;
                        r_dropped <= !r_last;
                        r_status  <= APP_TRUNC;
                        r_state   <= S_RES;
                    end else if (i_stat.seg_end) begin
                        r_state <= S_CHR;
                    end
                end
                S_CHR: begin
                    if (need_char && i_stat.full) begin
                        r_pending <= 1'b1;
                        r_dropped <= !r_last;
                        r_status  <= APP_TRUNC;
                        r_state   <= S_RES;
                    end else begin
                        r_state <= S_SUF;
                    end
                end
                S_SUF: begin
                    if (need_suf && i_stat.full) begin
                        r_pending <= 1'b1;
                        r_dropped <= !r_last;
                        r_status  <= APP_TRUNC;
                        r_state   <= S_RES;
                    end else if (!need_suf || i_stat.seg_end) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_COLD: begin
                    if (i_stat.out_free) begin
                        r_cold <= r_cold + 2'd1;
                        if (r_cold == COLD_LAST) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RD:   r_state <= S_DATA;
                S_DATA: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/print_spooler_with_escape_styles_core.sv -----
// Top level of the print spooler: controller plus datapath, request and result
// channels, config write port. Depends on pses_pkg, pses_if, pses_ctrl, pses_dpath.
//
// Requests come in one at a time on i_req; each transaction is a string byte, a
// flush, a restart or a service tick. A string byte is accepted, then goes through
// its steps in order: prefix bytes of a style written into the job buffer (e.g.
// up to ruler_width + 2 for a ruler), the character step, the suffix bytes (three
// for expanded; the suffix step is passed even when there is no suffix), and last
// the post of its status. A tick that sends a buffered byte goes through accept,
// buffer memory read and result load; a tick that ends a job through accept and
// done result load; a cold-start tick posts its four port writes; flush, restart
// and idle ticks end at acceptance. A result held on o_res stalls any of these
// while it waits. The single write port of the job buffer sets the pace of string
// appends. Results leave through a register, so a new request is taken while the
// last result still waits on o_res. The buffer needs no clearing pass after
// reset: only written entries are read.
module print_spooler_with_escape_styles_core import pses_pkg::*; #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pses_req_if.sink    i_req,
    pses_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence requests, track printer state and job flags.
    pses_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the job buffer, build escape bytes, drive the result register.
    pses_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_char     (i_req.char_byte),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res)
    );

endmodule

// ----- tb/print_spooler_with_escape_styles_core_tb.sv -----
// Self-checking testbench for the print spooler core: directed and random transactions
// checked against a behavioral spooler predictor. Depends on pses_pkg, pses_if and the RTL.
module print_spooler_with_escape_styles_core_tb import pses_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int BUF_BYTES      = 1024;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // Fixed byte sequence of the unit-symbol style.
    localparam logic [0:16][7:0] UNIT_SYMBOL = {
        8'h63, 8'h6d, CH_ESC, 8'h53, 8'h02, 8'h32, CH_ESC, 8'h54, 8'h2e,
        8'h67, CH_ESC, 8'h53, 8'h02, 8'h2d, 8'h31, CH_ESC, 8'h54
    };

    typedef enum logic [2:0] {CTL_STANDBY, CTL_COLDSTART, CTL_READY, CTL_RUNNING} t_ctl;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] style;
        logic [7:0] char_byte;
        logic       has_char;
        logic       first_of_string;
        logic       last_of_string;
    } t_spool_req;

    typedef struct packed {
        logic       port_select;
        logic [7:0] port_value;
        logic       strobe_res;
        logic       job_done;
        logic [1:0] append_status;
        logic       last_result;
    } t_spool_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_data;

    pses_req_if req_ch ();
    pses_res_if res_ch ();

    print_spooler_with_escape_styles_core #(
        .BUFFER_BYTES (BUF_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state: a private copy of the spooler and its two registers.
    t_ctl        ctl;
    logic [7:0]  job_mem [BUF_BYTES];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    bit          job_pending;
    bit          string_dropped;
    logic [2:0]  cur_style;
    logic [7:0]  ruler_width;
    logic [4:0]  eject_feeds;
    bit          byte_fits;

    t_spool_out  spool_outputs_due [$];

    bit idle_on = 1'b1;
    int items_sent = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Spooler predictor
    // ------------------------------------------------------------------
    function automatic void push_due_output(input logic sel, input logic [7:0] val,
                                            input logic strobe, input logic done,
                                            input logic [1:0] status, input logic fin);
        t_spool_out o;
        o.port_select   = sel;
        o.port_value    = val;
        o.strobe_res    = strobe;
        o.job_done      = done;
        o.append_status = status;
        o.last_result   = fin;
        spool_outputs_due.push_back(o);
    endfunction

    // Append one byte; once a byte misses, drop the rest of the string.
    function automatic void buffer_put(input logic [7:0] b);
        if (!byte_fits) return;
        if (wr_ptr < BUF_BYTES) begin
            job_mem[wr_ptr] = b;
            wr_ptr++;
        end else begin
            byte_fits = 1'b0;
        end
    endfunction

    function automatic logic [1:0] append_string_item(input t_spool_req r);
        int k;
        if (r.first_of_string) begin
            string_dropped = 1'b0;
            cur_style      = r.style;
        end
        // Reject while a job waits or while the rest of a cut string streams in.
        if (string_dropped || job_pending) begin
            string_dropped = !r.last_of_string;
            return APP_BUSY;
        end
        byte_fits = 1'b1;
        if (r.first_of_string) begin
            case (cur_style)
                STY_EXPANDED: begin
                    buffer_put(CH_ESC); buffer_put(8'h57); buffer_put(8'h01);
                end
                STY_RESET: begin
                    buffer_put(CH_ESC); buffer_put(8'h58);
                end
                STY_COMPRESSED: buffer_put(8'h0f);
                STY_EJECT: begin
                    for (k = 0; k < int'(eject_feeds); k++) buffer_put(CH_LF);
                    buffer_put(CH_CR);
                end
                STY_RULER: begin
                    for (k = 0; k < int'(ruler_width); k++) buffer_put(CH_DASH);
                    buffer_put(CH_CR); buffer_put(CH_LF);
                end
                STY_BLANK: begin
                    buffer_put(CH_CR); buffer_put(CH_LF);
                end
                STY_UNIT: begin
                    for (k = 0; k < 17; k++) buffer_put(UNIT_SYMBOL[k]);
                end
                default: ;
            endcase
        end
        // Only the text styles carry characters and a closing sequence.
        if (cur_style == STY_PLAIN || cur_style == STY_EXPANDED ||
            cur_style == STY_COMPRESSED) begin
            if (r.has_char) buffer_put(r.char_byte);
            if (r.last_of_string) begin
                if (cur_style == STY_EXPANDED) begin
                    buffer_put(CH_ESC); buffer_put(8'h57); buffer_put(8'h02);
                end else if (cur_style == STY_COMPRESSED) begin
                    buffer_put(8'h12);
                end
            end
        end
        if (!byte_fits) begin
            job_pending    = 1'b1;
            string_dropped = !r.last_of_string;
            return APP_TRUNC;
        end
        return APP_OK;
    endfunction

    function automatic void service_tick();
        case (ctl)
            CTL_COLDSTART: begin
                wr_ptr      = 0;
                rd_ptr      = 0;
                job_pending = 1'b0;
                push_due_output(PORT_DATA, 8'hff, 1'b0, 1'b0, APP_NONE, 1'b0);
                push_due_output(PORT_CTRL, 8'hff, 1'b0, 1'b0, APP_NONE, 1'b0);
                push_due_output(PORT_CTRL, 8'h8f, 1'b0, 1'b0, APP_NONE, 1'b0);
                push_due_output(PORT_CTRL, 8'hff, 1'b0, 1'b0, APP_NONE, 1'b1);
                ctl = CTL_READY;
            end
            CTL_READY: begin
                if (job_pending) ctl = CTL_RUNNING;
            end
            CTL_RUNNING: begin
                if (wr_ptr > rd_ptr) begin
                    push_due_output(PORT_DATA, job_mem[rd_ptr], 1'b1, 1'b0, APP_NONE, 1'b1);
                    rd_ptr++;
                end else begin
                    // Job finished (or was empty): clear and report done.
                    wr_ptr      = 0;
                    rd_ptr      = 0;
                    job_pending = 1'b0;
                    ctl         = CTL_READY;
                    push_due_output(PORT_DATA, 8'h00, 1'b0, 1'b1, APP_NONE, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_spooler(input t_spool_req r);
        case (r.mode)
            MODE_STRING:  push_due_output(PORT_DATA, 8'h00, 1'b0, 1'b0,
                                          append_string_item(r), 1'b1);
            MODE_FLUSH:   job_pending = 1'b1;
            MODE_RESTART: ctl = CTL_COLDSTART;
            default:      service_tick();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Transaction builders and driver
    // ------------------------------------------------------------------
    function automatic t_spool_req text_item(input logic [2:0] style, input logic [7:0] ch,
                                             input logic has, input logic sos,
                                             input logic eos);
        t_spool_req r;
        r.mode            = MODE_STRING;
        r.style           = style;
        r.char_byte       = ch;
        r.has_char        = has;
        r.first_of_string = sos;
        r.last_of_string  = eos;
        return r;
    endfunction

    // Flush, restart or tick; scramble the fields the block ignores.
    function automatic t_spool_req control_item(input logic [1:0] mode);
        t_spool_req r;
        r = text_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        r.mode = mode;
        return r;
    endfunction

    // Present one transaction, hold it until accepted, then predict its results.
    // Leave valid high afterwards so back-to-back transactions need no toggle.
    task automatic send_item(input t_spool_req r);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.mode            <= r.mode;
        req_ch.style           <= r.style;
        req_ch.char_byte       <= r.char_byte;
        req_ch.has_char        <= r.has_char;
        req_ch.first_of_string <= r.first_of_string;
        req_ch.last_of_string  <= r.last_of_string;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        predict_spooler(r);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result is out, plus a settling wait
    // of SETTLE_CYCLES for any flush, restart or idle tick still in flight.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (spool_outputs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle.
    task automatic set_config(input logic [7:0] ruler, input logic [4:0] feeds);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RULER;
        i_cfg_data <= ruler;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_EJECT;
        i_cfg_data <= {3'($urandom_range(0, 7)), feeds};   // upper bits are don't-care
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ruler_width = ruler;
        eject_feeds = feeds;
    endtask

    // Tick the pending job out; abort with a restart if it runs too long.
    task automatic drain_job(input int cap);
        int n;
        n = 0;
        while (job_pending && ctl != CTL_STANDBY && n < cap) begin
            send_item(control_item(MODE_TICK));
            n++;
        end
        if (job_pending && ctl != CTL_STANDBY) begin
            send_item(control_item(MODE_RESTART));
            send_item(control_item(MODE_TICK));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A standby tick and a string before cold start, cold start, idle ready tick, and an empty flushed job.
    task automatic test_power_up();
        idle_on = 1'b0;
        send_item(control_item(MODE_TICK));
        send_item(text_item(STY_PLAIN, 8'h41, 1'b1, 1'b1, 1'b1));
        send_item(control_item(MODE_RESTART));
        send_item(control_item(MODE_TICK));
        send_item(control_item(MODE_TICK));
        send_item(control_item(MODE_FLUSH));
        send_item(control_item(MODE_TICK));
        send_item(control_item(MODE_TICK));
    endtask

    // Every style, character extremes, continuation without a start, busy rejects.
    task automatic test_styles();
        idle_on = 1'b1;
        set_config(8'd1, 5'd0);
        send_item(text_item(STY_PLAIN, 8'h00, 1'b1, 1'b1, 1'b1));
        send_item(text_item(STY_EXPANDED, 8'hff, 1'b1, 1'b1, 1'b0));
        send_item(text_item(STY_PLAIN, 8'h41, 1'b1, 1'b0, 1'b0));
        send_item(text_item(STY_PLAIN, 8'h80, 1'b1, 1'b0, 1'b1));
        // No open string: falls back on the expanded style taken above.
        send_item(text_item(STY_UNIT, 8'h7f, 1'b1, 1'b0, 1'b1));
        send_item(text_item(STY_COMPRESSED, 8'h55, 1'b0, 1'b1, 1'b1));
        // Fixed style: the trailing item is accepted but writes nothing.
        send_item(text_item(STY_RESET, 8'haa, 1'b1, 1'b1, 1'b0));
        send_item(text_item(STY_PLAIN, 8'h33, 1'b1, 1'b0, 1'b1));
        send_item(text_item(STY_EJECT, 8'h01, 1'b1, 1'b1, 1'b1));
        send_item(text_item(STY_RULER, 8'hfe, 1'b1, 1'b1, 1'b1));
        send_item(text_item(STY_BLANK, 8'h10, 1'b1, 1'b1, 1'b1));
        send_item(text_item(STY_UNIT, 8'h20, 1'b1, 1'b1, 1'b1));
        send_item(control_item(MODE_FLUSH));
        send_item(text_item(STY_PLAIN, 8'h12, 1'b1, 1'b1, 1'b0));
        send_item(text_item(STY_PLAIN, 8'h34, 1'b1, 1'b0, 1'b1));
        drain_job(100);
        // Zero-width ruler gives only CR LF; eject at its widest.
        set_config(8'd0, 5'd31);
        send_item(text_item(STY_RULER, 8'h5a, 1'b1, 1'b1, 1'b1));
        send_item(text_item(STY_EJECT, 8'ha5, 1'b0, 1'b1, 1'b1));
        send_item(control_item(MODE_FLUSH));
        drain_job(100);
    endtask

    // Overflow of a fixed sequence and of text; rejects until the job clears.
    task automatic test_full_buffer();
        int k;
        set_config(8'd255, 5'd31);
        send_item(control_item(MODE_RESTART));
        send_item(control_item(MODE_TICK));
        for (k = 0; k < 3; k++) send_item(text_item(STY_RULER, 8'h00, 1'b1, 1'b1, 1'b1));
        send_item(text_item(STY_RULER, 8'h00, 1'b1, 1'b1, 1'b0));
        send_item(text_item(STY_PLAIN, 8'h61, 1'b1, 1'b0, 1'b1));
        send_item(text_item(STY_PLAIN, 8'h62, 1'b1, 1'b1, 1'b1));
        send_item(control_item(MODE_TICK));
        send_item(control_item(MODE_TICK));
        send_item(control_item(MODE_TICK));
        send_item(control_item(MODE_RESTART));
        send_item(control_item(MODE_TICK));
        // Leave exactly one free byte, then overflow on a text character.
        for (k = 0; k < 3; k++) send_item(text_item(STY_RULER, 8'h00, 1'b1, 1'b1, 1'b1));
        set_config(8'd250, 5'd31);
        send_item(text_item(STY_RULER, 8'h00, 1'b1, 1'b1, 1'b1));
        send_item(text_item(STY_PLAIN, 8'h63, 1'b1, 1'b1, 1'b0));
        send_item(text_item(STY_PLAIN, 8'h64, 1'b1, 1'b0, 1'b1));
        send_item(control_item(MODE_RESTART));
        send_item(control_item(MODE_TICK));
    endtask

    // One job of well-formed strings with random content, sprinkled with noise.
    task automatic random_job();
        int n_strings;
        int n_items;
        int s;
        int i;
        logic [2:0] sty;
        logic sos;
        logic eos;
        idle_on   = ($urandom_range(0, 3) != 0);
        n_strings = $urandom_range(1, 5);
        for (s = 0; s < n_strings; s++) begin
            n_items = $urandom_range(1, 4);
            // Favor text styles; fixed ones mostly produce long prefixes.
            if ($urandom_range(0, 4) < 3) begin
                case ($urandom_range(0, 2))
                    0:       sty = STY_PLAIN;
                    1:       sty = STY_EXPANDED;
                    default: sty = STY_COMPRESSED;
                endcase
            end else begin
                sty = 3'($urandom_range(0, 7));
            end
            for (i = 0; i < n_items; i++) begin
                sos = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                eos = (i == n_items - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
                send_item(text_item(sty, 8'($urandom_range(0, 255)),
                                    ($urandom_range(0, 7) != 0), sos, eos));
                if ($urandom_range(0, 15) == 0)
                    send_item(control_item(2'($urandom_range(1, 3))));
            end
        end
        if ($urandom_range(0, 7) != 0) send_item(control_item(MODE_FLUSH));
        drain_job(60);
        // Hold off now and then until all results are back.
        if ($urandom_range(0, 9) == 0) settle();
    endtask

    task automatic random_phase(input logic [7:0] ruler, input logic [4:0] feeds,
                                input int n_items);
        int stop_at;
        set_config(ruler, feeds);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) random_job();
    endtask

    task automatic test_random_traffic();
        random_phase(RULER_RESET, EJECT_RESET, 60);
        random_phase(8'($urandom_range(1, 255)), 5'($urandom_range(0, 31)), 60);
        random_phase(8'd1, 5'd0, 55);
        random_phase(8'd255, 5'd31, 55);
        random_phase(8'd0, 5'($urandom_range(0, 31)), 60);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (res_ch.valid !== 1'b1) @(posedge i_clk);
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) report_mismatch(what, want, got);
    endtask

    // Compare each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_spool_out got;
        t_spool_out want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.port_select   = res_ch.port_select;
            got.port_value    = res_ch.port_value;
            got.strobe_res    = res_ch.strobe_res;
            got.job_done      = res_ch.job_done;
            got.append_status = res_ch.append_status;
            got.last_result   = res_ch.last_result;
            if (spool_outputs_due.size() == 0) begin
                report_mismatch("result with nothing expected, port_value", 8'h00,
                                got.port_value);
            end else begin
                want = spool_outputs_due.pop_front();
                check_field("port_select", 8'(want.port_select), 8'(got.port_select));
                check_field("port_value", want.port_value, got.port_value);
                check_field("strobe_res", 8'(want.strobe_res), 8'(got.strobe_res));
                check_field("job_done", 8'(want.job_done), 8'(got.job_done));
                check_field("append_status", 8'(want.append_status),
                            8'(got.append_status));
                check_field("last_result", 8'(want.last_result), 8'(got.last_result));
            end
        end
    end

    // Stop the run if no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         spool_outputs_due.size());
                $display("** print_spooler_with_escape_styles_core: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value and hold reset.
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_RULER;
        i_cfg_data             <= 8'h00;
        req_ch.valid           <= 1'b0;
        req_ch.mode            <= MODE_STRING;
        req_ch.style           <= STY_PLAIN;
        req_ch.char_byte       <= 8'h00;
        req_ch.has_char        <= 1'b0;
        req_ch.first_of_string <= 1'b0;
        req_ch.last_of_string  <= 1'b0;

        ctl            = CTL_STANDBY;
        wr_ptr         = 0;
        rd_ptr         = 0;
        job_pending    = 1'b0;
        string_dropped = 1'b0;
        cur_style      = STY_PLAIN;
        ruler_width    = RULER_RESET;
        eject_feeds    = EJECT_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up();
        test_styles();
        test_full_buffer();
        test_random_traffic();

        // Let the last results out, then give the verdict.
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** print_spooler_with_escape_styles_core: PASSED **");
        end else begin
            $display("** print_spooler_with_escape_styles_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pses_pkg.sv
rtl/pses_if.sv
rtl/pses_dpath.sv
rtl/pses_ctrl.sv
rtl/print_spooler_with_escape_styles_core.sv
tb/print_spooler_with_escape_styles_core_tb.sv
